[hw/rtl/prl_pkg.sv]
// ----------------------------------------------------------------------------
// prl_pkg
// Shared types and constants for the patch record loader: channel words,
// result kinds, register indexes and parser phase encoding.
// ----------------------------------------------------------------------------
package prl_pkg;

   // Input word: one byte of the patch file plus end-of-file flag
   typedef struct packed {
      logic [7:0] byte_in;
      logic       last_byte;
   } req_type;

   // Result word
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] address;
      logic [7:0]  data;
   } rsp_type;

   // Result kinds
   localparam logic [1:0] KIND_MEM_WRITE     = 2'd0;
   localparam logic [1:0] KIND_SECTION_START = 2'd1;
   localparam logic [1:0] KIND_OUT_OF_BOUNDS = 2'd2;
   localparam logic [1:0] KIND_MALFORMED_LEN = 2'd3;

   // Register indexes
   localparam logic CSR_WRITE_RAM_OPCODE = 1'b0;
   localparam logic CSR_IMAGE_SIZE       = 1'b1;

   // Register reset values
   localparam logic [15:0] WRITE_RAM_OPCODE_RESET = 16'hFC4C;
   localparam logic [31:0] IMAGE_SIZE_RESET       = 32'h0024_0000;

   // Bytes of target address at the head of a write-RAM body
   localparam logic [7:0] ADDR_BYTES = 8'd4;

   // Parser phase, one-hot
   typedef enum logic [5:0] {
      PH_CMD_LO = 6'b000001,
      PH_CMD_HI = 6'b000010,
      PH_LEN    = 6'b000100,
      PH_ADDR   = 6'b001000,
      PH_DATA   = 6'b010000,
      PH_SKIP   = 6'b100000
   } phase_type;

endpackage

[hw/rtl/prl_parser.sv]
// ----------------------------------------------------------------------------
// prl_parser
// Record parser: holds the record state and, for each byte stepped in while
// not halted, updates that state and forms at most one result word.
// ----------------------------------------------------------------------------
module prl_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  prl_pkg::req_type req_word,
   input  logic [15:0]      write_ram_opcode,
   input  logic [31:0]      image_size,
   output logic             res_valid,
   output prl_pkg::rsp_type res_word
);
   import prl_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [15:0] command_word_ff, command_word_in;
   logic [7:0]  record_length_ff, record_length_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [31:0] target_address_ff, target_address_in;
   logic [31:0] write_pointer_ff, write_pointer_in;
   logic [31:0] expected_next_ff, expected_next_in;
   logic        first_record_ff, first_record_in;
   logic        halted_ff, halted_in;

   logic [7:0]  b;
   logic [7:0]  left_dec;
   logic [1:0]  addr_idx;
   logic [31:0] addr_full;
   logic [32:0] bound_sum;
   logic        is_write_cmd;

   assign b         = req_word.byte_in;
   assign left_dec  = bytes_left_ff - 8'd1;
   assign addr_idx  = record_length_ff[1:0] - bytes_left_ff[1:0];
   assign addr_full = target_address_ff | (32'(b) << {addr_idx, 3'b000});
   assign bound_sum = {1'b0, addr_full} + 33'(record_length_ff);
   assign is_write_cmd = (command_word_ff == write_ram_opcode);

   always_comb begin
      logic stop;
      logic new_section;
      stop              = 1'b0;
      new_section       = 1'b0;
      phase_in          = phase_ff;
      command_word_in   = command_word_ff;
      record_length_in  = record_length_ff;
      bytes_left_in     = bytes_left_ff;
      target_address_in = target_address_ff;
      write_pointer_in  = write_pointer_ff;
      expected_next_in  = expected_next_ff;
      first_record_in   = first_record_ff;
      halted_in         = halted_ff;
      res_valid         = 1'b0;
      res_word          = '0;

      if (step && !halted_ff) begin
         case (phase_ff)
            PH_CMD_LO: begin
               command_word_in = {8'h00, b};
               phase_in        = PH_CMD_HI;
            end
            PH_CMD_HI: begin
               command_word_in = {b, command_word_ff[7:0]};
               phase_in        = PH_LEN;
            end
            PH_LEN: begin
               record_length_in  = b;
               bytes_left_in     = b;
               target_address_in = '0;
               if (is_write_cmd && (b >= ADDR_BYTES)) begin
                  phase_in = PH_ADDR;
               end else begin
                  if (is_write_cmd) begin
                     res_valid     = 1'b1;
                     res_word.kind = KIND_MALFORMED_LEN;
                  end
                  phase_in = (b == 8'd0) ? PH_CMD_LO : PH_SKIP;
               end
            end
            PH_ADDR: begin
               target_address_in = addr_full;
               bytes_left_in     = left_dec;
               if (addr_idx == 2'd3) begin
                  new_section      = first_record_ff || (expected_next_ff != addr_full);
                  first_record_in  = 1'b0;
                  expected_next_in = addr_full + 32'(record_length_ff) - 32'(ADDR_BYTES);
                  if (bound_sum > {1'b0, image_size}) begin
                     // fatal: report the record and drop everything until reset
                     res_valid        = 1'b1;
                     res_word.kind    = KIND_OUT_OF_BOUNDS;
                     res_word.address = addr_full;
                     halted_in        = 1'b1;
                     phase_in         = PH_CMD_LO;
                     stop             = 1'b1;
                  end else begin
                     if (new_section) begin
                        res_valid        = 1'b1;
                        res_word.kind    = KIND_SECTION_START;
                        res_word.address = addr_full;
                     end
                     write_pointer_in = addr_full;
                     phase_in = (left_dec == 8'd0) ? PH_CMD_LO : PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               res_valid        = 1'b1;
               res_word.kind    = KIND_MEM_WRITE;
               res_word.address = write_pointer_ff;
               res_word.data    = b;
               write_pointer_in = write_pointer_ff + 32'd1;
               bytes_left_in    = left_dec;
               if (left_dec == 8'd0) begin
                  phase_in = PH_CMD_LO;
               end
            end
            PH_SKIP: begin
               if (bytes_left_ff != 8'd0) begin
                  bytes_left_in = left_dec;
               end
               if (bytes_left_ff <= 8'd1) begin
                  phase_in = PH_CMD_LO;
               end
            end
            default: begin
               phase_in = PH_CMD_LO;
            end
         endcase

         // end of file: abandon any partial record, next file opens a section
         if (req_word.last_byte && !stop) begin
            phase_in        = PH_CMD_LO;
            bytes_left_in   = '0;
            first_record_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_CMD_LO;
         command_word_ff   <= '0;
         record_length_ff  <= '0;
         bytes_left_ff     <= '0;
         target_address_ff <= '0;
         write_pointer_ff  <= '0;
         expected_next_ff  <= '0;
         first_record_ff   <= 1'b1;
         halted_ff         <= 1'b0;
      end else begin
         phase_ff          <= phase_in;
         command_word_ff   <= command_word_in;
         record_length_ff  <= record_length_in;
         bytes_left_ff     <= bytes_left_in;
         target_address_ff <= target_address_in;
         write_pointer_ff  <= write_pointer_in;
         expected_next_ff  <= expected_next_in;
         first_record_ff   <= first_record_in;
         halted_ff         <= halted_in;
      end
   end

endmodule

[hw/rtl/patch_record_loader_core.sv]
// ----------------------------------------------------------------------------
// patch_record_loader_core
// Byte-stream parser for patch files: turns write-RAM records into memory
// write words, flags section starts, and reports bad records.
//
//   Channel  Dir  Ports                          Word
//   -------  ---  -----------------------------  -------------------------
//   req      in   req_valid/req_ready/req_word   byte_in, last_byte
//   rsp      out  rsp_valid/rsp_ready/rsp_word   kind, address, data
//   csr      in   csr_we/csr_index/csr_wdata     write_ram_opcode, image_size
//
// One byte per cycle sustained while rsp_ready holds: a byte is registered at
// the input, parsed once the output register has room, and its result (if
// any) lands in the output register. The parse step advances whenever a byte
// is held and the output register is empty or being drained in the same
// cycle.
// A stall on rsp_ready holds the output word and backs up into the input
// register; reset is synchronous and returns the parser to record start.
// ----------------------------------------------------------------------------
module patch_record_loader_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  prl_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output prl_pkg::rsp_type rsp_word,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [31:0]      csr_wdata
);
   import prl_pkg::*;

   // configuration registers
   logic [15:0] opcode_ff;
   logic [31:0] image_size_ff;

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_word_ff;

   // output register
   logic    out_valid_ff, out_valid_in;
   rsp_type out_word_ff;

   logic    advance;
   logic    res_valid;
   rsp_type res_word;

   // parse the held byte once the output side has room for its result
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = res_valid;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   prl_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .step             (advance),
      .req_word         (in_word_ff),
      .write_ram_opcode (opcode_ff),
      .image_size       (image_size_ff),
      .res_valid        (res_valid),
      .res_word         (res_word)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         opcode_ff     <= WRITE_RAM_OPCODE_RESET;
         image_size_ff <= IMAGE_SIZE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_WRITE_RAM_OPCODE: opcode_ff     <= csr_wdata[15:0];
               CSR_IMAGE_SIZE:       image_size_ff <= csr_wdata;
               default:              image_size_ff <= image_size_ff;
            endcase
         end
      end
   end

   // payload: input word loads on accept, output word on a parsed result; hold otherwise
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_word;
      end
      if (advance && res_valid) begin
         out_word_ff <= res_word;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule
